// ===== rtl/miq_pkg.sv =====
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and codes for the middle insert indexed queue: request
// opcodes, result status codes, controller states and the result bundle.
// ----------------------------------------------------------------------------
package miq_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned INDEX_W  = 10;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_GET        = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_PUSH_FRONT = 2'd2,
    OP_PUSH_MID   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_FINISH = 2'b10
  } state_e;

  // work left for the finish state of a request
  typedef enum logic [2:0] {
    PEND_GET_FRONT = 3'd0,
    PEND_GET_BACK  = 3'd1,
    PEND_TO_FRONT  = 3'd2,
    PEND_TO_BACK   = 3'd3,
    PEND_RANGE     = 3'd4,
    PEND_FULL      = 3'd5
  } pend_e;

  // one result headed for the output register
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    status_e                  status;
  } res_t;

endpackage

// ===== rtl/miq_ram.sv =====
// ----------------------------------------------------------------------------
// miq_ram
// Single ring storage: one write port and one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module miq_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic [miq_pkg::DATA_W-1:0]        wdata_i,
  input  logic                              re_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic [miq_pkg::DATA_W-1:0]        rdata_o
);

  logic [miq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [miq_pkg::DATA_W-1:0] rdata_q;

  // write port and read-before-write read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/miq_ctrl.sv =====
// ----------------------------------------------------------------------------
// miq_ctrl
// Queue controller: keeps heads and counts of both rings, turns each request
// into ring reads and writes, and finishes gets, refused requests and
// rebalancing moves in the finish state, once any read data is back.
// ----------------------------------------------------------------------------
module miq_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned HALF     = 512,
  parameter int unsigned AW       = 9,
  parameter int unsigned NW       = 10,
  parameter int unsigned TW       = 11
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [miq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [miq_pkg::DATA_W-1:0] value_i,
  input  logic [miq_pkg::INDEX_W-1:0]       index_i,
  input  logic                              out_busy_i,
  output logic                              in_stall_o,
  output miq_pkg::res_t                     res_o,
  // front ring port
  output logic                              f_we_o,
  output logic [AW-1:0]                     f_waddr_o,
  output logic [miq_pkg::DATA_W-1:0]        f_wdata_o,
  output logic                              f_re_o,
  output logic [AW-1:0]                     f_raddr_o,
  input  logic [miq_pkg::DATA_W-1:0]        f_rdata_i,
  // back ring port
  output logic                              b_we_o,
  output logic [AW-1:0]                     b_waddr_o,
  output logic [miq_pkg::DATA_W-1:0]        b_wdata_o,
  output logic                              b_re_o,
  output logic [AW-1:0]                     b_raddr_o,
  input  logic [miq_pkg::DATA_W-1:0]        b_rdata_i
);

  localparam int unsigned SW = NW + 1;
  localparam int unsigned GW = (TW > miq_pkg::INDEX_W) ? TW : miq_pkg::INDEX_W;

  // ring position head + offset, offset never above the ring depth
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [NW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(head) + SW'(off);
    if (sum >= SW'(HALF)) begin
      sum = sum - SW'(HALF);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] head);
    return (head == '0) ? AW'(HALF - 1) : head - 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] head);
    return (head == AW'(HALF - 1)) ? '0 : head + 1'b1;
  endfunction

  miq_pkg::state_e state_q, state_d;
  miq_pkg::pend_e  pend_q, pend_d;
  logic [AW-1:0]   pend_addr_q, pend_addr_d;
  logic [AW-1:0]   front_head_q, front_head_d;
  logic [AW-1:0]   back_head_q, back_head_d;
  logic [NW-1:0]   front_count_q, front_count_d;
  logic [NW-1:0]   back_count_q, back_count_d;

  logic            accept;
  logic [TW-1:0]   total;
  logic [GW-1:0]   idx_g;
  logic [GW-1:0]   front_g;
  logic [NW-1:0]   off_front;
  logic [NW-1:0]   off_back;
  miq_pkg::op_e    op;

  assign op         = miq_pkg::op_e'(opcode_i);
  assign in_stall_o = (state_q != miq_pkg::ST_IDLE) | out_busy_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign total      = TW'(front_count_q) + TW'(back_count_q);
  assign idx_g      = GW'(index_i);
  assign front_g    = GW'(front_count_q);
  assign off_front  = NW'(idx_g);
  assign off_back   = NW'(idx_g - front_g);

  // request decode, ring access and bookkeeping
  always_comb begin
    state_d       = state_q;
    pend_d        = pend_q;
    pend_addr_d   = pend_addr_q;
    front_head_d  = front_head_q;
    back_head_d   = back_head_q;
    front_count_d = front_count_q;
    back_count_d  = back_count_q;
    f_we_o        = 1'b0;
    f_waddr_o     = '0;
    f_wdata_o     = value_i;
    f_re_o        = 1'b0;
    f_raddr_o     = '0;
    b_we_o        = 1'b0;
    b_waddr_o     = '0;
    b_wdata_o     = value_i;
    b_re_o        = 1'b0;
    b_raddr_o     = '0;
    res_o         = '0;

    unique case (state_q)
      miq_pkg::ST_IDLE: begin
        if (accept) begin
          if (op == miq_pkg::OP_GET) begin
            state_d = miq_pkg::ST_FINISH;
            if (idx_g >= GW'(total)) begin
              pend_d = miq_pkg::PEND_RANGE;
            end else if (idx_g < front_g) begin
              pend_d    = miq_pkg::PEND_GET_FRONT;
              f_re_o    = 1'b1;
              f_raddr_o = ring_pos(front_head_q, off_front);
            end else begin
              pend_d    = miq_pkg::PEND_GET_BACK;
              b_re_o    = 1'b1;
              b_raddr_o = ring_pos(back_head_q, off_back);
            end
          end else if (total >= TW'(CAPACITY)) begin
            state_d = miq_pkg::ST_FINISH;
            pend_d  = miq_pkg::PEND_FULL;
          end else begin
            unique case (op)
              miq_pkg::OP_PUSH_BACK: begin
                if (back_count_q == front_count_q && back_count_q == '0) begin
                  // empty queue: first element lands in the front ring
                  f_we_o        = 1'b1;
                  f_waddr_o     = ring_pos(front_head_q, front_count_q);
                  front_count_d = front_count_q + 1'b1;
                end else if (back_count_q == front_count_q) begin
                  // move back head to front tail, then append
                  b_re_o        = 1'b1;
                  b_raddr_o     = back_head_q;
                  b_we_o        = 1'b1;
                  b_waddr_o     = ring_pos(back_head_q, back_count_q);
                  back_head_d   = ring_next(back_head_q);
                  pend_d        = miq_pkg::PEND_TO_FRONT;
                  pend_addr_d   = ring_pos(front_head_q, front_count_q);
                  front_count_d = front_count_q + 1'b1;
                  state_d       = miq_pkg::ST_FINISH;
                end else begin
                  b_we_o       = 1'b1;
                  b_waddr_o    = ring_pos(back_head_q, back_count_q);
                  back_count_d = back_count_q + 1'b1;
                end
              end
              miq_pkg::OP_PUSH_FRONT: begin
                f_we_o       = 1'b1;
                f_waddr_o    = ring_prev(front_head_q);
                front_head_d = ring_prev(front_head_q);
                if (front_count_q > back_count_q) begin
                  // move front tail to back head; read sees the old entry
                  f_re_o       = 1'b1;
                  f_raddr_o    = ring_pos(front_head_q, front_count_q - 1'b1);
                  back_head_d  = ring_prev(back_head_q);
                  back_count_d = back_count_q + 1'b1;
                  pend_d       = miq_pkg::PEND_TO_BACK;
                  pend_addr_d  = ring_prev(back_head_q);
                  state_d      = miq_pkg::ST_FINISH;
                end else begin
                  front_count_d = front_count_q + 1'b1;
                end
              end
              miq_pkg::OP_PUSH_MID: begin
                if (front_count_q > back_count_q) begin
                  b_we_o       = 1'b1;
                  b_waddr_o    = ring_prev(back_head_q);
                  back_head_d  = ring_prev(back_head_q);
                  back_count_d = back_count_q + 1'b1;
                end else begin
                  f_we_o        = 1'b1;
                  f_waddr_o     = ring_pos(front_head_q, front_count_q);
                  front_count_d = front_count_q + 1'b1;
                end
              end
              default: begin
                state_d = miq_pkg::ST_IDLE;
              end
            endcase
          end
        end
      end
      miq_pkg::ST_FINISH: begin
        state_d = miq_pkg::ST_IDLE;
        case (pend_q)
          miq_pkg::PEND_GET_FRONT: begin
            res_o.valid  = 1'b1;
            res_o.data   = f_rdata_i;
            res_o.status = miq_pkg::STAT_OK;
          end
          miq_pkg::PEND_GET_BACK: begin
            res_o.valid  = 1'b1;
            res_o.data   = b_rdata_i;
            res_o.status = miq_pkg::STAT_OK;
          end
          miq_pkg::PEND_TO_FRONT: begin
            f_we_o    = 1'b1;
            f_waddr_o = pend_addr_q;
            f_wdata_o = b_rdata_i;
          end
          miq_pkg::PEND_TO_BACK: begin
            b_we_o    = 1'b1;
            b_waddr_o = pend_addr_q;
            b_wdata_o = f_rdata_i;
          end
          miq_pkg::PEND_RANGE: begin
            res_o.valid  = 1'b1;
            res_o.status = miq_pkg::STAT_RANGE;
          end
          miq_pkg::PEND_FULL: begin
            res_o.valid  = 1'b1;
            res_o.status = miq_pkg::STAT_FULL;
          end
          default: begin
            res_o.valid = 1'b0;
          end
        endcase
      end
      default: begin
        state_d = miq_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= miq_pkg::ST_IDLE;
      pend_q        <= miq_pkg::PEND_RANGE;
      front_head_q  <= '0;
      back_head_q   <= '0;
      front_count_q <= '0;
      back_count_q  <= '0;
    end else begin
      state_q       <= state_d;
      pend_q        <= pend_d;
      front_head_q  <= front_head_d;
      back_head_q   <= back_head_d;
      front_count_q <= front_count_d;
      back_count_q  <= back_count_d;
    end
  end

  // deferred write address
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
  end

  // halves stay balanced: front holds the back count or one more
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_count_q == back_count_q) || (SW'(front_count_q) == SW'(back_count_q) + 1'b1))
    else $error("ring halves out of balance");

  // never more elements than capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= TW'(CAPACITY))
    else $error("element count above capacity");

  // the finishing cycle is a single cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == miq_pkg::ST_FINISH) |=> (state_q == miq_pkg::ST_IDLE))
    else $error("finish state held");

  // ring heads stay inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SW'(front_head_q) < SW'(HALF)) && (SW'(back_head_q) < SW'(HALF)))
    else $error("ring head out of range");

endmodule

// ===== rtl/middle_insert_indexed_queue.sv =====
// ----------------------------------------------------------------------------
// middle_insert_indexed_queue
// Queue of 32-bit elements with push at front, back or middle and read by
// index, kept as two balanced ring halves in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_stall_o) carries opcode, value, index.
//   Result channel (out_valid_o / out_stall_i) carries data and status.
//   A get always yields one result; a push yields a result only when the
//   queue is full (status full, data zero). A get past the count yields
//   status range with data zero.
// Request flow:
//   A get, a refused push and a push that moves an element between halves
//   pass through the finish state, in which no new request is taken; other
//   pushes complete when accepted. A result is captured in the output
//   register from the finish state. Each ring has one registered read
//   port: a moved element is read first and written into the other ring in
//   the next cycle.
// Reset:
//   Clears heads and counts; the queue is empty at once, no memory sweep.
// Stall:
//   While a result sits in the output register and out_stall_i is high, new
//   requests are stalled; the held result does not change.
// ----------------------------------------------------------------------------
module middle_insert_indexed_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [miq_pkg::OP_W-1:0]          opcode_i,
  input  logic signed [miq_pkg::DATA_W-1:0] value_i,
  input  logic [miq_pkg::INDEX_W-1:0]       index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [miq_pkg::DATA_W-1:0] data_o,
  output logic [miq_pkg::STATUS_W-1:0]      status_o
);

  localparam int unsigned HALF = (CAPACITY + 1) / 2;
  localparam int unsigned AW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned NW   = $clog2(HALF + 1);
  localparam int unsigned TW   = $clog2(CAPACITY + 1);

  logic                       f_we, f_re, b_we, b_re;
  logic [AW-1:0]              f_waddr, f_raddr, b_waddr, b_raddr;
  logic [miq_pkg::DATA_W-1:0] f_wdata, f_rdata, b_wdata, b_rdata;
  miq_pkg::res_t              res;
  logic                       out_busy;

  logic                              out_valid_q, out_valid_d;
  logic signed [miq_pkg::DATA_W-1:0] out_data_q;
  miq_pkg::status_e                  out_status_q;

  assign out_busy = out_valid_q & out_stall_i;

  miq_ctrl #(
    .CAPACITY (CAPACITY),
    .HALF     (HALF),
    .AW       (AW),
    .NW       (NW),
    .TW       (TW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .out_busy_i (out_busy),
    .in_stall_o (in_stall_o),
    .res_o      (res),
    .f_we_o     (f_we),
    .f_waddr_o  (f_waddr),
    .f_wdata_o  (f_wdata),
    .f_re_o     (f_re),
    .f_raddr_o  (f_raddr),
    .f_rdata_i  (f_rdata),
    .b_we_o     (b_we),
    .b_waddr_o  (b_waddr),
    .b_wdata_o  (b_wdata),
    .b_re_o     (b_re),
    .b_raddr_o  (b_raddr),
    .b_rdata_i  (b_rdata)
  );

  // front half ring
  miq_ram #(
    .DEPTH (HALF),
    .AW    (AW)
  ) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // back half ring
  miq_ram #(
    .DEPTH (HALF),
    .AW    (AW)
  ) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q   <= res.data;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign status_o    = out_status_q;

  // a new result only lands in an empty output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> !out_valid_q)
    else $error("result overwrote a pending result");

  // no request taken while the output register is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |-> in_stall_o)
    else $error("request accepted while result held");

  // a held result stays valid with the same data and status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_busy |=> out_valid_q && $stable(out_data_q) && $stable(out_status_q))
    else $error("held result changed");

endmodule

// ===== verif/middle_insert_indexed_queue_test.sv =====
// ----------------------------------------------------------------------------
// middle_insert_indexed_queue_test
// Self-checking bench for the middle insert indexed queue. A directed list of
// requests covers empty reads, each push opcode and the balancing shifts. A
// random list then fills the queue to capacity, mixed with reads, and ends
// with reads and refused pushes. Replies are predicted by a two-half queue model and
// compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module middle_insert_indexed_queue_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW           = miq_pkg::DATA_W;
  localparam int unsigned IW           = miq_pkg::INDEX_W;
  localparam int unsigned QUEUE_DEPTH  = 1024;
  localparam int unsigned RANDOM_ITEMS = 1150;
  localparam int unsigned MIN_REFUSED  = 30;
  localparam int unsigned IDLE_LIMIT   = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    miq_pkg::op_e      op;
    logic [DW-1:0]     value;
    logic [IW-1:0]     index;
    int unsigned       gap;
  } request_t;

  typedef struct {
    logic [DW-1:0]     data;
    miq_pkg::status_e  status;
  } reply_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // block ports
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [miq_pkg::OP_W-1:0]     opcode_i = miq_pkg::OP_GET;
  logic [DW-1:0]                value_i = '0;
  logic [IW-1:0]                index_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [DW-1:0]                data_o;
  logic [miq_pkg::STATUS_W-1:0] status_o;

  middle_insert_indexed_queue #(
    .CAPACITY(QUEUE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .value_i    (value_i),
    .index_i    (index_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .data_o     (data_o),
    .status_o   (status_o)
  );

  // request list, queue model and replies still owed
  request_t      request_q[$];
  reply_t        reply_q[$];
  logic [DW-1:0] front_half[$];
  logic [DW-1:0] back_half[$];

  int unsigned fail_count = 0;
  int unsigned fill = 0;
  int unsigned refused = 0;
  int unsigned added = 0;
  bit          calm_driver = 1'b0;

  // append a request, tracking the fill level it will reach
  task automatic add_request(miq_pkg::op_e op, logic [DW-1:0] v, logic [IW-1:0] idx);
    request_t r;
    if ($urandom_range(0, 39) == 0) calm_driver = !calm_driver;
    r.op    = op;
    r.value = v;
    r.index = idx;
    r.gap   = calm_driver ? 0 : $urandom_range(0, 8);
    request_q = {request_q, r};
    added++;
    if (op != miq_pkg::OP_GET) begin
      if (fill < QUEUE_DEPTH) fill++;
      else refused++;
    end
  endtask

  // apply one accepted request to the model, queueing any reply it owes
  task automatic queue_apply(miq_pkg::op_e op, logic [DW-1:0] v, logic [IW-1:0] idx);
    reply_t        r;
    int unsigned   total;
    logic [DW-1:0] moved;
    total    = front_half.size() + back_half.size();
    r.data   = '0;
    r.status = miq_pkg::STAT_OK;
    if (op == miq_pkg::OP_GET) begin
      if (idx >= total) r.status = miq_pkg::STAT_RANGE;
      else if (idx < front_half.size()) r.data = front_half[idx];
      else r.data = back_half[idx - front_half.size()];
      reply_q = {reply_q, r};
    end else if (total >= QUEUE_DEPTH) begin
      r.status = miq_pkg::STAT_FULL;
      reply_q = {reply_q, r};
    end else begin
      case (op)
        miq_pkg::OP_PUSH_BACK: begin
          if (back_half.size() == 0 && front_half.size() == 0) begin
            front_half = {front_half, v};
          end else begin
            // equal halves: first of the back half moves to the front tail
            if (back_half.size() == front_half.size()) begin
              moved = back_half[0];
              back_half.delete(0);
              front_half = {front_half, moved};
            end
            back_half = {back_half, v};
          end
        end
        miq_pkg::OP_PUSH_FRONT: begin
          // front half one longer: its tail moves to the back head
          if (front_half.size() > back_half.size()) begin
            moved = front_half[front_half.size() - 1];
            front_half.delete(front_half.size() - 1);
            back_half.insert(0, moved);
          end
          front_half.insert(0, v);
        end
        default: begin
          if (front_half.size() > back_half.size()) back_half.insert(0, v);
          else front_half = {front_half, v};
        end
      endcase
    end
  endtask

  // request driver
  request_t    next_req;
  request_t    cur_req;
  bit          armed = 1'b0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        queue_apply(cur_req.op, cur_req.value, cur_req.index);
      if (!in_valid_i || !in_stall_o) begin
        if (!armed && request_q.size() > 0) begin
          next_req = request_q[0];
          request_q.delete(0);
          gap_left = next_req.gap;
          armed    = 1'b1;
        end
        if (armed && gap_left == 0) begin
          cur_req    = next_req;
          armed      = 1'b0;
          in_valid_i <= 1'b1;
          opcode_i   <= cur_req.op;
          value_i    <= cur_req.value;
          index_i    <= cur_req.index;
        end else begin
          in_valid_i <= 1'b0;
          if (armed) gap_left--;
        end
      end
    end
  end

  // reply monitor with random stall
  int unsigned stall_left = 0;
  bit          calm_monitor = 1'b0;

  always @(posedge clk_i) begin : monitor
    reply_t want;
    if (rst_ni && out_valid_o) begin
      if (!out_stall_i) begin
        if (reply_q.size() == 0) begin
          $error("reply with none expected: data %h status %0d", data_o, status_o);
          fail_count++;
        end else begin
          want = reply_q[0];
          reply_q.delete(0);
          if (data_o !== want.data) begin
            $error("data mismatch: expected %h, got %h", want.data, data_o);
            fail_count++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) calm_monitor = !calm_monitor;
        stall_left = calm_monitor ? 0 : $urandom_range(0, 8);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // watchdog on cycles without any handshake
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    int unsigned   pick;
    miq_pkg::op_e  op;
    logic [DW-1:0] v;
    logic [IW-1:0] idx;

    // empty queue reads, every push path, balancing shifts
    add_request(miq_pkg::OP_GET, '0, '0);
    add_request(miq_pkg::OP_GET, '0, 10'h3ff);
    add_request(miq_pkg::OP_PUSH_MID, 32'h0000_0001, '0);
    add_request(miq_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 10'h3ff);
    add_request(miq_pkg::OP_PUSH_BACK, 32'h8000_0000, '0);
    add_request(miq_pkg::OP_PUSH_BACK, 32'hffff_ffff, '0);
    add_request(miq_pkg::OP_PUSH_FRONT, 32'h0000_0000, '0);
    add_request(miq_pkg::OP_PUSH_FRONT, 32'h5555_5555, '0);
    add_request(miq_pkg::OP_PUSH_MID, 32'haaaa_aaaa, '0);
    add_request(miq_pkg::OP_PUSH_MID, 32'h1234_5678, '0);
    for (int i = 0; i <= 8; i++) add_request(miq_pkg::OP_GET, '0, IW'(i));
    add_request(miq_pkg::OP_PUSH_FRONT, 32'hdead_beef, '0);
    add_request(miq_pkg::OP_PUSH_MID, 32'h0f0f_f0f0, '0);
    add_request(miq_pkg::OP_GET, '0, 10'h3ff);
    add_request(miq_pkg::OP_GET, '0, 10'd4);

    // random mix: mostly pushes until full, then reads and refused pushes
    while (added < RANDOM_ITEMS || refused < MIN_REFUSED) begin
      if (fill < QUEUE_DEPTH) pick = ($urandom_range(0, 99) < 90) ? 1 : 0;
      else pick = $urandom_range(0, 1);
      if (pick != 0) begin
        case ($urandom_range(0, 2))
          0:       op = miq_pkg::OP_PUSH_BACK;
          1:       op = miq_pkg::OP_PUSH_FRONT;
          default: op = miq_pkg::OP_PUSH_MID;
        endcase
      end else begin
        op = miq_pkg::OP_GET;
      end
      case ($urandom_range(0, 19))
        0:       v = 32'h0000_0000;
        1:       v = 32'hffff_ffff;
        2:       v = 32'h7fff_ffff;
        3:       v = 32'h8000_0000;
        default: v = $urandom;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 5 && fill > 0) idx = IW'($urandom_range(0, fill - 1));
      else if (pick == 5 && fill > 0) idx = IW'(fill - 1);
      else if (pick == 6) idx = (fill > 1023) ? 10'h3ff : IW'(fill);
      else idx = IW'($urandom_range(0, 1023));
      add_request(op, v, idx);
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || armed || in_valid_i || reply_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/miq_pkg.sv
rtl/miq_ram.sv
rtl/miq_ctrl.sv
rtl/middle_insert_indexed_queue.sv
verif/middle_insert_indexed_queue_test.sv
